[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, masked while reset is held
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  `ASSERT_PROP(label, clk, rst_n, !(expr), msg)

`endif

[rtl/ljp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ljp_pkg
// Shared constants, codes and types of the Lennard-Jones probe block.
// ---------------------------------------------------------------------------
package ljp_pkg;

  localparam int MAX_ATOMS_DEF = 512;

  // field widths
  localparam int COORD_W  = 16;
  localparam int HEIGHT_W = 15;
  localparam int INDEX_W  = 9;
  localparam int COUNT_W  = 10;
  localparam int COEFF_W  = 32;
  localparam int POT_W    = 32;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;
  localparam int WIDE_CNT_W = 17;  // holds any depth up to 65536

  // arithmetic
  localparam int Q840_W  = 48;
  localparam int HALF_W  = 24;
  localparam int PROD_W  = 96;
  localparam int FRAC_SH = 40;
  localparam int R2_W    = 35;
  localparam int ACC_W   = 52;
  localparam logic [Q840_W-1:0] Q840_MAX = {Q840_W{1'b1}};
  // r2 at or below this gives a reciprocal beyond Q8.40 range
  localparam logic [R2_W-1:0] RECIP_CLAMP_R2 = R2_W'(256);

  // configuration
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_REP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_ATT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATOM_CNT  = 2'd2;
  localparam logic [COEFF_W-1:0] COEFF_REP_RST = 32'd1579417600;
  localparam logic [COEFF_W-1:0] COEFF_ATT_RST = 32'd996147;
  localparam logic [COUNT_W-1:0] ATOM_CNT_RST  = 10'd512;

  // item kinds
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [Q840_W-1:0] inv;
  } recip_res_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [Q840_W-1:0] val;
  } mul_res_t;

endpackage

[rtl/ljp_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ljp_ram
// Single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ljp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/ljp_recip.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ljp_recip
// Bit-serial restoring divider: floor(2^56 / r2) in Q8.40, one bit a cycle.
// ---------------------------------------------------------------------------
module ljp_recip (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ljp_pkg::R2_W-1:0]    r2,
  output ljp_pkg::recip_res_t         res
);

  localparam int CW = $clog2(ljp_pkg::Q840_W);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic                         sat_r, sat_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [ljp_pkg::R2_W-1:0]     d_r, d_nxt;
  logic [ljp_pkg::R2_W-1:0]     rem_r, rem_nxt;
  logic [ljp_pkg::Q840_W-1:0]   q_r, q_nxt;
  logic [ljp_pkg::R2_W:0]       trial;
  logic                         ge;

  assign trial = {rem_r, 1'b0};
  assign ge    = trial >= {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sat_nxt  = sat_r;
    cnt_nxt  = cnt_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      d_nxt = r2;
      if (r2 <= ljp_pkg::RECIP_CLAMP_R2) begin
        // zero or tiny distance: clamp straight away
        done_nxt = 1'b1;
        sat_nxt  = 1'b1;
        q_nxt    = ljp_pkg::Q840_MAX;
      end else begin
        // upper quotient bits are zero; remainder after them is 2^8
        busy_nxt = 1'b1;
        sat_nxt  = 1'b0;
        rem_nxt  = ljp_pkg::RECIP_CLAMP_R2;
        cnt_nxt  = CW'(ljp_pkg::Q840_W - 1);
      end
    end else if (busy_r) begin
      rem_nxt = ge ? ljp_pkg::R2_W'(trial - {1'b0, d_r}) : ljp_pkg::R2_W'(trial);
      q_nxt   = {q_r[ljp_pkg::Q840_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sat_r <= sat_nxt;
    cnt_r <= cnt_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign res.done = done_r;
  assign res.sat  = sat_r;
  assign res.inv  = q_r;

endmodule

[rtl/ljp_mul.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ljp_mul
// 48x48 multiply over four 24x24 passes, result >> 40 clamped to Q8.40.
// ---------------------------------------------------------------------------
module ljp_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ljp_pkg::Q840_W-1:0]   a,
  input  logic [ljp_pkg::Q840_W-1:0]   b,
  output ljp_pkg::mul_res_t            res
);

  localparam int HW = ljp_pkg::HALF_W;
  localparam int PW = ljp_pkg::PROD_W;

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [1:0]                  k_r, k_nxt;
  logic [ljp_pkg::Q840_W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [PW-1:0]               prod_r, prod_nxt;
  logic [HW-1:0]               a_part, b_part;
  logic [2*HW-1:0]             pp;
  logic [PW-1:0]               term;
  logic [PW-ljp_pkg::FRAC_SH-1:0] shifted;

  assign a_part = k_r[0] ? a_r[2*HW-1:HW] : a_r[HW-1:0];
  assign b_part = k_r[1] ? b_r[2*HW-1:HW] : b_r[HW-1:0];
  assign pp     = a_part * b_part;

  always_comb begin
    unique case (k_r)
      2'd0:    term = PW'(pp);
      2'd1,
      2'd2:    term = PW'(pp) << HW;
      2'd3:    term = PW'(pp) << (2 * HW);
      default: term = '0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    k_nxt    = k_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    prod_nxt = prod_r;
    if (start) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
      a_nxt    = a;
      b_nxt    = b;
      prod_nxt = '0;
    end else if (busy_r) begin
      prod_nxt = prod_r + term;
      k_nxt    = k_r + 1'b1;
      if (k_r == 2'd3) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    k_r    <= k_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
  end

  assign shifted  = prod_r[PW-1:ljp_pkg::FRAC_SH];
  assign res.done = done_r;
  assign res.ovf  = |shifted[PW-ljp_pkg::FRAC_SH-1:ljp_pkg::Q840_W];
  assign res.val  = res.ovf ? ljp_pkg::Q840_MAX : shifted[ljp_pkg::Q840_W-1:0];

endmodule

[rtl/lennard_jones_probe_potential.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lennard_jones_probe_potential
// Sums the 12-6 Lennard-Jones potential of stored atoms at a probe point.
// ---------------------------------------------------------------------------
// Use:
//   in_*  : one transaction per item. tuser = func (0 load, 1 query).
//           A load writes the atom's x,y into its slot and yields nothing;
//           it leaves the block idle. A query yields one out_* transaction.
//   out_* : tdata = potential (Q16.16), tuser = saturated.
//   cfg_* : register writes, only while the block is idle.
// Flow: atoms are read one at a time from the coordinate RAM. Each atom
//   passes through the read and r^2 steps, the bit-serial reciprocal
//   (cut short when it clamps) and 5 products on the shared 24x24
//   multiplier. A query sums min(atom_count, MAX_ATOMS) atoms; a count
//   of zero goes straight to the result.
// Reset: configuration returns to its defaults; the coordinate RAM is not
//   cleared and a slot must be loaded before a query reads it.
// Stall: a finished result sits in the output register; the next item is
//   accepted meanwhile, and a later query waits before its result only
//   while that register is still full.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lennard_jones_probe_potential #(
  parameter int MAX_ATOMS = ljp_pkg::MAX_ATOMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: atom_index[8:0], pos_x[24:9], pos_y[40:25], probe_height[55:41]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ljp_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tuser,   // func
  // out_tdata: potential[31:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ljp_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tuser,  // saturated
  input  logic                              cfg_wr_en,
  input  logic [ljp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [ljp_pkg::COEFF_W-1:0]       cfg_wdata
);

  localparam int AW   = $clog2(MAX_ATOMS);
  localparam int CNTW = $clog2(MAX_ATOMS + 1);
  localparam int CW   = ljp_pkg::COORD_W;
  localparam int QW   = ljp_pkg::Q840_W;
  localparam int WC   = ljp_pkg::WIDE_CNT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_R2   = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_P2   = 4'd5;
  localparam logic [3:0] S_P3   = 4'd6;
  localparam logic [3:0] S_P6   = 4'd7;
  localparam logic [3:0] S_REP  = 4'd8;
  localparam logic [3:0] S_ATT  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  // input fields
  logic [ljp_pkg::INDEX_W-1:0]  f_idx;
  logic [CW-1:0]                f_x, f_y;
  logic [ljp_pkg::HEIGHT_W-1:0] f_z;

  assign f_idx = in_tdata[8:0];
  assign f_x   = in_tdata[24:9];
  assign f_y   = in_tdata[40:25];
  assign f_z   = in_tdata[55:41];

  logic [3:0]                       state_r, state_nxt;
  logic [ljp_pkg::COEFF_W-1:0]      coeff_rep_r, coeff_att_r;
  logic [ljp_pkg::COUNT_W-1:0]      atom_cnt_r;
  logic [CNTW-1:0]                  cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic signed [CW-1:0]             px_r, px_nxt, py_r, py_nxt;
  logic [2*ljp_pkg::HEIGHT_W-1:0]   z2_r, z2_nxt;
  logic [2*CW:0]                    dx2_r, dx2_nxt, dy2_r, dy2_nxt;
  logic [QW-1:0]                    inv_r, inv_nxt, p3_r, p3_nxt, rep_r, rep_nxt;
  logic signed [ljp_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic                             sat_r, sat_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [ljp_pkg::POT_W-1:0]        pot_r, pot_nxt;
  logic                             osat_r, osat_nxt;

  logic                             in_acc;
  logic                             ram_we, ram_re;
  logic [WC-1:0]                    idx_wide, cnt_wide, cnt_cap;
  logic [2*CW-1:0]                  ram_rdata;
  logic signed [CW:0]               dx, dy;
  logic signed [2*CW+1:0]           dx_sq, dy_sq;
  logic [ljp_pkg::R2_W-1:0]         r2;
  logic                             rcp_start, mul_start;
  logic [QW-1:0]                    mul_a, mul_b;
  ljp_pkg::recip_res_t              rcp;
  ljp_pkg::mul_res_t                mul;
  logic                             out_free;
  logic signed [ljp_pkg::ACC_W-1:0] pos_lim, neg_lim;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign idx_wide  = WC'(f_idx);
  assign ram_we    = in_acc && (in_tuser == ljp_pkg::FUNC_LOAD) &&
                     (idx_wide < WC'(MAX_ATOMS));
  assign ram_re    = (state_r == S_READ);

  assign cnt_wide = WC'(atom_cnt_r);
  assign cnt_cap  = (cnt_wide > WC'(MAX_ATOMS)) ? WC'(MAX_ATOMS) : cnt_wide;

  ljp_ram #(
    .WIDTH(2 * CW),
    .DEPTH(MAX_ATOMS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(idx_wide)),
    .wdata({f_y, f_x}),
    .re   (ram_re),
    .raddr(idx_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  // exact squared distance
  assign dx    = {px_r[CW-1], px_r} - {ram_rdata[CW-1], ram_rdata[CW-1:0]};
  assign dy    = {py_r[CW-1], py_r} - {ram_rdata[2*CW-1], ram_rdata[2*CW-1:CW]};
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;
  assign r2    = ljp_pkg::R2_W'(dx2_r) + ljp_pkg::R2_W'(dy2_r) + ljp_pkg::R2_W'(z2_r);

  assign rcp_start = (state_r == S_R2);

  ljp_recip u_recip (
    .clk  (clk),
    .rst_n(rst_n),
    .start(rcp_start),
    .r2   (r2),
    .res  (rcp)
  );

  ljp_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .res  (mul)
  );

  assign out_free = !out_valid_r || out_tready;
  assign pos_lim  = ljp_pkg::ACC_W'(64'sd2147483647);
  assign neg_lim  = -ljp_pkg::ACC_W'(64'sd2147483648);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    z2_nxt        = z2_r;
    dx2_nxt       = dx2_r;
    dy2_nxt       = dy2_r;
    inv_nxt       = inv_r;
    p3_nxt        = p3_r;
    rep_nxt       = rep_r;
    acc_nxt       = acc_r;
    sat_nxt       = sat_r;
    pot_nxt       = pot_r;
    osat_nxt      = osat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mul_start     = 1'b0;
    mul_a         = mul.val;
    mul_b         = mul.val;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == ljp_pkg::FUNC_QUERY)) begin
          px_nxt  = f_x;
          py_nxt  = f_y;
          z2_nxt  = f_z * f_z;
          cnt_nxt = CNTW'(cnt_cap);
          idx_nxt = '0;
          acc_nxt = '0;
          sat_nxt = 1'b0;
          state_nxt = (cnt_cap == '0) ? S_DONE : S_READ;
        end
      end
      S_READ: state_nxt = S_SQ;
      S_SQ: begin
        dx2_nxt   = dx_sq[2*CW:0];
        dy2_nxt   = dy_sq[2*CW:0];
        state_nxt = S_R2;
      end
      S_R2: state_nxt = S_DIV;
      S_DIV: begin
        if (rcp.done) begin
          inv_nxt   = rcp.inv;
          sat_nxt   = sat_r | rcp.sat;
          mul_start = 1'b1;
          mul_a     = rcp.inv;
          mul_b     = rcp.inv;
          state_nxt = S_P2;
        end
      end
      S_P2: begin
        if (mul.done) begin
          sat_nxt   = sat_r | mul.ovf;
          mul_start = 1'b1;
          mul_b     = inv_r;
          state_nxt = S_P3;
        end
      end
      S_P3: begin
        if (mul.done) begin
          p3_nxt    = mul.val;
          sat_nxt   = sat_r | mul.ovf;
          mul_start = 1'b1;
          state_nxt = S_P6;
        end
      end
      S_P6: begin
        if (mul.done) begin
          sat_nxt   = sat_r | mul.ovf;
          mul_start = 1'b1;
          mul_a     = QW'(coeff_rep_r);
          state_nxt = S_REP;
        end
      end
      S_REP: begin
        if (mul.done) begin
          rep_nxt   = mul.val;
          mul_start = 1'b1;
          mul_a     = QW'(coeff_att_r);
          mul_b     = p3_r;
          state_nxt = S_ATT;
        end
      end
      S_ATT: begin
        if (mul.done) begin
          acc_nxt   = acc_r + $signed(ljp_pkg::ACC_W'(rep_r))
                            - $signed(ljp_pkg::ACC_W'(mul.val));
          idx_nxt   = idx_r + 1'b1;
          state_nxt = (idx_nxt == cnt_r) ? S_DONE : S_READ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          priority if (acc_r > pos_lim) begin
            pot_nxt  = {1'b0, {(ljp_pkg::POT_W-1){1'b1}}};
            osat_nxt = 1'b1;
          end else if (acc_r < neg_lim) begin
            pot_nxt  = {1'b1, {(ljp_pkg::POT_W-1){1'b0}}};
            osat_nxt = 1'b1;
          end else begin
            pot_nxt  = acc_r[ljp_pkg::POT_W-1:0];
            osat_nxt = sat_r;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      coeff_rep_r <= ljp_pkg::COEFF_REP_RST;
      coeff_att_r <= ljp_pkg::COEFF_ATT_RST;
      atom_cnt_r  <= ljp_pkg::ATOM_CNT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_idx)
          ljp_pkg::CFG_COEFF_REP: coeff_rep_r <= cfg_wdata;
          ljp_pkg::CFG_COEFF_ATT: coeff_att_r <= cfg_wdata;
          ljp_pkg::CFG_ATOM_CNT:  atom_cnt_r  <= cfg_wdata[ljp_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
    end
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    z2_r   <= z2_nxt;
    dx2_r  <= dx2_nxt;
    dy2_r  <= dy2_nxt;
    inv_r  <= inv_nxt;
    p3_r   <= p3_nxt;
    rep_r  <= rep_nxt;
    acc_r  <= acc_nxt;
    sat_r  <= sat_nxt;
    pot_r  <= pot_nxt;
    osat_r <= osat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = pot_r;
  assign out_tuser  = osat_r;

  `ASSERT_PROP(a_no_load_busy, clk, rst_n, (state_r != S_IDLE) |-> !ram_we, "RAM written during a query")
  `ASSERT_PROP(a_idx_bound, clk, rst_n, (state_r != S_IDLE) |-> (idx_r <= cnt_r), "atom index past count")
  `ASSERT_NEVER(a_units_overlap, clk, rst_n, rcp.done && mul.done, "reciprocal and multiplier finished together")
  `ASSERT_PROP(a_hold_result, clk, rst_n, (state_r == S_DONE && out_valid_r && !out_tready) |=> (state_r == S_DONE), "result overwrote a pending one")

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lennard-Jones probe potential testbench
// Loads atom coordinates and fires probe queries at the block, with random
// gaps and stalls on both sides. Every returned energy and saturation flag is
// checked against an in-bench fixed-point 12-6 model or a stimulus value.
// ----------------------------------------------------------------------------
module testbench;
  import ljp_pkg::*;

  localparam int NATOMS = MAX_ATOMS_DEF;
  localparam logic [63:0] RECIP_MAX = 64'(Q840_MAX);

  typedef struct packed {
    logic [31:0] pot;
    logic        sat;
  } energy_t;

  typedef struct {
    logic        func;
    logic [8:0]  idx;
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] z;
    bit          known;
    logic [31:0] pot;
    logic        sat;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [IN_DATA_W-1:0] in_tdata;
  logic out_tvalid, out_tready, out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COEFF_W-1:0] cfg_wdata;

  // model state
  logic signed [15:0] atom_x[NATOMS];
  logic signed [15:0] atom_y[NATOMS];
  logic [31:0] b_coeff, a_coeff;
  logic [9:0]  n_atoms;

  energy_t energy_q[$];
  int  n_errors = 0;
  bit  calm = 1'b0;
  int  hold_req = 0;

  lennard_jones_probe_potential dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20ms;
    $display("testbench failed");
    $finish;
  end

  task automatic report(input string what);
    n_errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  function automatic logic [63:0] mul_q40(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[103:40];
  endfunction

  function automatic logic [63:0] clamp_q840(input logic [63:0] v, inout logic sat);
    if (v > RECIP_MAX) begin
      sat = 1'b1;
      return RECIP_MAX;
    end
    return v;
  endfunction

  function automatic energy_t probe_energy(input logic signed [15:0] px,
                                           input logic signed [15:0] py,
                                           input logic [14:0] z);
    longint acc, dx, dy;
    logic [63:0] r2, inv, p2, p3, p6;
    int n;
    energy_t e;
    acc = 0;
    e.sat = 1'b0;
    n = (n_atoms > NATOMS) ? NATOMS : n_atoms;
    for (int i = 0; i < n; i++) begin
      dx = longint'(px) - longint'(atom_x[i]);
      dy = longint'(py) - longint'(atom_y[i]);
      r2 = 64'(dx * dx) + 64'(dy * dy) + 64'(z) * 64'(z);
      if (r2 == 0) begin
        inv = RECIP_MAX;
        e.sat = 1'b1;
      end else begin
        inv = clamp_q840((64'd1 << 56) / r2, e.sat);
      end
      p2 = clamp_q840(mul_q40(inv, inv), e.sat);
      p3 = clamp_q840(mul_q40(p2, inv), e.sat);
      p6 = clamp_q840(mul_q40(p3, p3), e.sat);
      acc += longint'(mul_q40(64'(b_coeff), p6)) - longint'(mul_q40(64'(a_coeff), p3));
    end
    if (acc > 64'sd2147483647) begin
      acc = 64'sd2147483647;
      e.sat = 1'b1;
    end
    if (acc < -64'sd2147483648) begin
      acc = -64'sd2147483648;
      e.sat = 1'b1;
    end
    e.pot = acc[31:0];
    return e;
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left, hold_seen;
    energy_t want;
    stall_left = 0;
    hold_seen = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (energy_q.size() == 0) begin
          report($sformatf("unexpected result %h", out_tdata));
        end else begin
          want = energy_q.pop_front();
          if (out_tdata !== want.pot)
            report($sformatf("potential %h, want %h", out_tdata, want.pot));
          if (out_tuser !== want.sat)
            report($sformatf("saturated %b, want %b", out_tuser, want.sat));
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        stall_left = 1500;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (calm || $urandom_range(0, 99) < 70) begin
        out_tready <= 1'b1;
      end else begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        out_tready <= 1'b0;
      end
    end
  end

  task automatic send(input logic func, input logic [8:0] idx, input logic [15:0] x,
                      input logic [15:0] y, input logic [14:0] z,
                      input bit known = 0, input energy_t typed = '0);
    int gap, r;
    r = $urandom_range(0, 99);
    gap = calm ? 0 : (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {z, y, x, idx};
    do @(posedge clk); while (!in_tready);
    // transaction taken at this edge
    if (func == FUNC_LOAD) begin
      atom_x[idx] = x;
      atom_y[idx] = y;
    end else begin
      energy_q.insert(energy_q.size(), known ? typed : probe_energy(x, y, z));
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (energy_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] b, input logic [31:0] a, input logic [9:0] n);
    cfg_wr_en <= 1'b1;
    cfg_idx   <= CFG_COEFF_REP;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_idx   <= CFG_COEFF_ATT;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_idx   <= CFG_ATOM_CNT;
    cfg_wdata <= 32'(n);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    b_coeff = b;
    a_coeff = a;
    n_atoms = n;
  endtask

  function automatic logic [15:0] rand_coord(input logic [15:0] near);
    if ($urandom_range(0, 1)) return near + 16'($signed($urandom_range(0, 2047)) - 1024);
    return 16'($urandom);
  endfunction

  function automatic logic [14:0] rand_height();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return '0;
    if (r < 7) return 15'($urandom_range(0, 1023));
    return 15'($urandom);
  endfunction

  stim_row_t dir_rows[] = '{
    '{FUNC_LOAD,  9'd0,   16'h0000, 16'h0000, 15'h0000, 0, 32'h0, 1'b0},
    '{FUNC_QUERY, 9'd0,   16'h0000, 16'h0000, 15'h0000, 1, 32'h7FFFFFFF, 1'b1},
    '{FUNC_QUERY, 9'd0,   16'h7FFF, 16'h7FFF, 15'h7FFF, 0, 32'h0, 1'b0},
    '{FUNC_LOAD,  9'd0,   16'h8000, 16'h8000, 15'h0000, 0, 32'h0, 1'b0},
    '{FUNC_QUERY, 9'd0,   16'h7FFF, 16'h7FFF, 15'h7FFF, 0, 32'h0, 1'b0},
    '{FUNC_QUERY, 9'd0,   16'h8000, 16'h8000, 15'h7FFF, 0, 32'h0, 1'b0},
    '{FUNC_LOAD,  9'd0,   16'h0100, 16'h0000, 15'h0000, 0, 32'h0, 1'b0},
    '{FUNC_QUERY, 9'd0,   16'h0000, 16'h0000, 15'h0000, 0, 32'h0, 1'b0},
    '{FUNC_QUERY, 9'd0,   16'h0110, 16'h0000, 15'h0000, 0, 32'h0, 1'b0},
    '{FUNC_QUERY, 9'd0,   16'h0100, 16'h0010, 15'h0001, 0, 32'h0, 1'b0},
    '{FUNC_QUERY, 9'd0,   16'h0100, 16'h0000, 15'h0180, 0, 32'h0, 1'b0},
    '{FUNC_QUERY, 9'd511, 16'h0400, 16'hFC00, 15'h0300, 0, 32'h0, 1'b0},
    '{FUNC_LOAD,  9'd511, 16'hFFFF, 16'h7FFF, 15'h7FFF, 0, 32'h0, 1'b0},
    '{FUNC_LOAD,  9'd0,   16'h1234, 16'hEDCB, 15'h5555, 0, 32'h0, 1'b0},
    '{FUNC_QUERY, 9'd1,   16'h1200, 16'hEE00, 15'h2AAA, 0, 32'h0, 1'b0}
  };

  initial begin
    logic [31:0] b, a;
    logic [9:0]  n;
    logic [15:0] px, py;
    int k;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= FUNC_LOAD;
    in_tdata <= '0;
    cfg_wr_en <= 1'b0;
    cfg_idx <= CFG_COEFF_REP;
    cfg_wdata <= '0;
    b_coeff = COEFF_REP_RST;
    a_coeff = COEFF_ATT_RST;
    n_atoms = ATOM_CNT_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // the directed rows load slot 0 before any query, so sum a single atom
    configure(COEFF_REP_RST, COEFF_ATT_RST, 10'd1);
    foreach (dir_rows[i])
      send(dir_rows[i].func, dir_rows[i].idx, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
           dir_rows[i].known, '{pot: dir_rows[i].pot, sat: dir_rows[i].sat});
    settle();

    // empty sum
    configure(32'hFFFFFFFF, 32'hFFFFFFFF, 10'd0);
    for (int i = 0; i < 3; i++)
      send(FUNC_QUERY, 9'($urandom), 16'($urandom), 16'($urandom), 15'($urandom), 1, '0);
    settle();

    // fill every slot so that any count reads written atoms only
    for (int i = 0; i < NATOMS; i++)
      send(FUNC_LOAD, 9'(i), rand_coord(16'h0000), rand_coord(16'h0000), '0);

    for (int ph = 0; ph < 11; ph++) begin
      settle();
      calm = (ph == 5);
      b = $urandom;
      a = $urandom;
      n = 10'($urandom_range(1, 6));
      case (ph)
        0: b = 32'd0;
        1: begin b = 32'hFFFFFFFF; a = 32'd0; end
        2: a = 32'hFFFFFFFF;
        3: begin b = COEFF_REP_RST; a = COEFF_ATT_RST; end
        8: n = 10'd512;
        9: n = 10'd1023;
        10: n = 10'd513;
        default: ;
      endcase
      configure(b, a, n);
      k = (n > 10'd8) ? 2 : 52;
      for (int i = 0; i < k; i++) begin
        if (ph == 2 && i == 10) hold_req++;
        if (k > 2 || $urandom_range(0, 1) == 0) begin
          px = atom_x[$urandom_range(0, 5)];
          py = atom_y[$urandom_range(0, 5)];
        end else begin
          px = 16'($urandom);
          py = 16'($urandom);
        end
        if (k > 2 && $urandom_range(0, 99) < 50)
          send(FUNC_LOAD, 9'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                          : $urandom_range(0, 7)),
               rand_coord(px), rand_coord(py), 15'($urandom));
        else
          send(FUNC_QUERY, 9'($urandom), rand_coord(px), rand_coord(py), rand_height());
      end
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (energy_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
